>>> hdl/pamq_pkg.sv
// shared types, operation and status codes for the mailbox queue block
// no dependencies
package pamq_pkg;

  localparam int SLOT_COUNT_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam logic [2:0] OP_REGISTER   = 3'd0;
  localparam logic [2:0] OP_UNREGISTER = 3'd1;
  localparam logic [2:0] OP_SEND       = 3'd2;
  localparam logic [2:0] OP_RECEIVE    = 3'd3;
  localparam logic [2:0] OP_BROADCAST  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // kind in the lowest bits, correlation in the highest
  typedef struct packed {
    logic [63:0] correlation;
    logic [63:0] tstamp;
    logic [15:0] length;
    logic [63:0] payload;
    logic [63:0] recipient;
    logic [63:0] sender;
    logic [7:0]  kind;
  } msg_t;

  // write/read request from sequencer to message store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> hdl/pamq_msg_mem.sv
// message store: one write port, one registered read port
// depends on pamq_pkg
module pamq_msg_mem #(
  parameter int ADDR_W = 11
) (
  input  logic                clk,
  input  pamq_pkg::mem_ctl_t  ctl,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  pamq_pkg::msg_t      wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output pamq_pkg::msg_t      rd_data
);

  pamq_pkg::msg_t mem_r [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> hdl/per_agent_mailbox_queues.sv
// mailbox queue block top level: slot table, sequencer, message store
// depends on pamq_pkg and pamq_msg_mem
//
//  channel | dir | transfer when              | contents
//  in_     | in  | in_tvalid & in_tready      | operation, agent, ..., now_seconds
//  out_    | out | out_tvalid & out_tready    | status, pending, received message
//  cfg_    | in  | cfg_we                     | active_slots
//
// with used = min(active_slots, SLOT_COUNT), an operation searches the first used slots,
// one slot compared per cycle by the shared id comparator, then executes; receive adds
// a store read, broadcast walks the slots once more, one slot per cycle, writing the
// message store for each valid slot but the sender's whose queue has room
// in_tready is low from transfer until the result is taken
// reset clears slot table and pointers; message store is not cleared
module per_agent_mailbox_queues #(
  parameter int SLOT_COUNT  = pamq_pkg::SLOT_COUNT_DEF,
  parameter int QUEUE_DEPTH = pamq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[2:0], agent, sender, message_kind, payload_handle,
  // payload_length, correlation, now_seconds (347 bits, padded to 352)
  input  logic [351:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], pending, out_kind, out_sender, out_recipient, out_payload,
  // out_length, out_time, out_correlation (354 bits, padded to 360)
  output logic [359:0] out_tdata,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int AW = SW + PW;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_EXEC, S_BCAST, S_READ, S_COUNT, S_OUT
  } state_t;

  state_t state_r;
  logic [SLOT_COUNT-1:0] valid_r;
  logic [63:0]   agent_id_r [SLOT_COUNT];
  logic [PW-1:0] rp_r [SLOT_COUNT];
  logic [PW-1:0] wp_r [SLOT_COUNT];
  logic [3:0]    active_r;

  logic [2:0]  op_r;
  logic [63:0] agent_r, sender_r;
  logic [7:0]  kind_r;
  logic [63:0] pay_r, corr_r, now_r;
  logic [15:0] len_r;

  logic [SW-1:0] idx_r;
  logic          found_r, free_found_r, found2_r;
  logic [SW-1:0] hit_r, free_r, hit2_r;
  logic [1:0]    status_r;
  logic [7:0]    pend_r;
  pamq_pkg::msg_t rmsg_r;
  logic          rx_r;

  logic [CW-1:0] used;
  assign used = (int'(active_r) > SLOT_COUNT) ? CW'(SLOT_COUNT) : CW'(active_r);

  logic idx_last;
  assign idx_last = (CW'(idx_r) + 1'b1 >= used);

  // shared comparator
  logic [63:0] cmp_key;
  logic        cmp_eq;
  assign cmp_key = (state_r == S_BCAST) ? sender_r : agent_r;
  assign cmp_eq  = (agent_id_r[idx_r] == cmp_key);

  pamq_pkg::mem_ctl_t mctl;
  logic [AW-1:0] waddr, raddr;
  pamq_pkg::msg_t wmsg, rdata;
  logic [PW-1:0] wp_cur, rp_cur, wp_inc, rp_inc;
  logic q_full, hit_ok;

  assign hit_ok = found_r;
  assign wp_cur = wp_r[(state_r == S_BCAST) ? idx_r : hit_r];
  assign rp_cur = rp_r[(state_r == S_BCAST) ? idx_r : hit_r];
  assign wp_inc = (wp_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_cur + 1'b1;
  assign rp_inc = (rp_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_cur + 1'b1;
  assign q_full = (wp_inc == rp_cur);

  always_comb begin
    mctl = '0;
    wmsg.kind = kind_r;
    wmsg.sender = sender_r;
    wmsg.payload = pay_r;
    wmsg.length = len_r;
    wmsg.tstamp = now_r;
    if (state_r == S_BCAST) begin
      wmsg.recipient = agent_id_r[idx_r];
      wmsg.correlation = '0;
      waddr = {idx_r, wp_cur};
      mctl.wr_en = (CW'(idx_r) < used) && valid_r[idx_r] && !cmp_eq && !q_full;
    end else begin
      wmsg.recipient = agent_r;
      wmsg.correlation = corr_r;
      waddr = {hit_r, wp_cur};
      mctl.wr_en = (state_r == S_EXEC) && (op_r == pamq_pkg::OP_SEND) && hit_ok && !q_full;
    end
    raddr = {hit_r, rp_cur};
    mctl.rd_en = (state_r == S_EXEC) && (op_r == pamq_pkg::OP_RECEIVE) && hit_ok
                 && (rp_cur != wp_cur);
  end

  pamq_msg_mem #(.ADDR_W(AW)) u_mem (
    .clk(clk), .ctl(mctl), .wr_addr(waddr), .wr_data(wmsg),
    .rd_addr(raddr), .rd_data(rdata)
  );

  logic [PW-1:0] cnt;
  logic hit_valid;
  assign hit_valid = found_r;
  assign cnt = wp_r[hit_r] - rp_r[hit_r] +
               ((wp_r[hit_r] < rp_r[hit_r]) ? PW'(QUEUE_DEPTH) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      active_r <= 4'd8;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        agent_id_r[i] <= '0;
        rp_r[i] <= '0;
        wp_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r <= in_tdata[2:0];
            agent_r <= in_tdata[66:3];
            sender_r <= in_tdata[130:67];
            kind_r <= in_tdata[138:131];
            pay_r <= in_tdata[202:139];
            len_r <= in_tdata[218:203];
            corr_r <= in_tdata[282:219];
            now_r <= in_tdata[346:283];
            idx_r <= '0;
            found_r <= 1'b0;
            found2_r <= 1'b0;
            free_found_r <= 1'b0;
            hit_r <= '0;
            hit2_r <= '0;
            free_r <= '0;
            status_r <= pamq_pkg::ST_OK;
            rx_r <= 1'b0;
            state_r <= (used == '0) ? S_EXEC : S_FIND;
          end
        end
        S_FIND: begin
          if (!found_r && valid_r[idx_r] && cmp_eq) begin
            found_r <= 1'b1;
            hit_r <= idx_r;
          end
          // next slot holding the same agent, used once the first is freed
          if (found_r && !found2_r && valid_r[idx_r] && cmp_eq) begin
            found2_r <= 1'b1;
            hit2_r <= idx_r;
          end
          if (!free_found_r && !valid_r[idx_r]) begin
            free_found_r <= 1'b1;
            free_r <= idx_r;
          end
          if (idx_last) begin
            state_r <= S_EXEC;
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EXEC: begin
          state_r <= S_COUNT;
          case (op_r)
            pamq_pkg::OP_REGISTER: begin
              if (!found_r) begin
                if (free_found_r) begin
                  valid_r[free_r] <= 1'b1;
                  agent_id_r[free_r] <= agent_r;
                  rp_r[free_r] <= '0;
                  wp_r[free_r] <= '0;
                  found_r <= 1'b1;
                  hit_r <= free_r;
                end else begin
                  status_r <= pamq_pkg::ST_FULL;
                end
              end
            end
            pamq_pkg::OP_UNREGISTER: begin
              if (found_r) begin
                rp_r[hit_r] <= wp_r[hit_r];
                valid_r[hit_r] <= 1'b0;
                found_r <= found2_r;
                hit_r <= hit2_r;
              end else begin
                status_r <= pamq_pkg::ST_NOTFOUND;
              end
            end
            pamq_pkg::OP_SEND: begin
              if (!found_r) begin
                status_r <= pamq_pkg::ST_NOTFOUND;
              end else if (q_full) begin
                status_r <= pamq_pkg::ST_FULL;
              end else begin
                wp_r[hit_r] <= wp_inc;
              end
            end
            pamq_pkg::OP_RECEIVE: begin
              if (!found_r || rp_cur == wp_cur) begin
                status_r <= pamq_pkg::ST_NOTFOUND;
              end else begin
                rp_r[hit_r] <= rp_inc;
                rx_r <= 1'b1;
                state_r <= S_READ;
              end
            end
            pamq_pkg::OP_BROADCAST: begin
              state_r <= (used == '0) ? S_COUNT : S_BCAST;
            end
            default: ;
          endcase
        end
        S_BCAST: begin
          if (mctl.wr_en) begin
            wp_r[idx_r] <= wp_inc;
          end
          if (idx_last) begin
            state_r <= S_COUNT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_READ: begin
          rmsg_r <= rdata;
          state_r <= S_COUNT;
        end
        S_COUNT: begin
          if (!rx_r) begin
            rmsg_r <= '0;
          end
          if (hit_valid) begin
            pend_r <= (PW > 8 && cnt > PW'(255)) ? 8'd255 : 8'(cnt);
          end else begin
            pend_r <= '0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, rmsg_r, pend_r, status_r};

  property p_no_overlap;
    @(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid);
  endproperty
  assert property (p_no_overlap) else $error("ready while result pending");

  property p_status_code;
    @(posedge clk) disable iff (!rst_n) out_tvalid |-> (out_tdata[1:0] != 2'd3);
  endproperty
  assert property (p_status_code) else $error("bad status code");

  property p_rx_ok;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && rx_r) |-> (status_r == pamq_pkg::ST_OK);
  endproperty
  assert property (p_rx_ok) else $error("received message without ok status");

  property p_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata));
  endproperty
  assert property (p_hold) else $error("result dropped");

endmodule
